// ----- rtl/rfse_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the ring FIFO with search and extrema.
// Used by the top level and the port checker; depends on nothing.
package rfse_pkg;

  // Request codes; 5 to 7 are ignored requests
  localparam logic [2:0] FN_PUSH   = 3'd0;
  localparam logic [2:0] FN_POP    = 3'd1;
  localparam logic [2:0] FN_SEARCH = 3'd2;
  localparam logic [2:0] FN_HEAVY  = 3'd3;
  localparam logic [2:0] FN_FEWEST = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam int TWW = 36;
  localparam logic [TWW-1:0] TW_MAX = '1;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] tag;
    logic [31:0] weight;
    logic [15:0] boxes;
  } rec_t;

endpackage

// ----- rtl/ring_fifo_with_search_and_extrema.sv -----
`timescale 1ns / 1ps
// Ring FIFO of records (key, tag, weight, box count) with key search and
// heaviest / fewest-boxes queries. Uses rfse_pkg and one rfse_ram instance.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: func selects
//   push, pop, search, heaviest or fewest boxes; key, tag, weight and boxes
//   are the record fields. Every request yields exactly one result on the
//   output channel (out_valid / out_stall) with status, found, full flag,
//   occupancy, total weight and the reported record.
//   Push, rejected and ignored requests go straight to the result state; a
//   pop first reads the head entry, and search and extrema scan all queued
//   entries, reading one entry per cycle through the single RAM read port
//   and one shared comparator. One request is in flight at a time; in_stall
//   is high from accept until the result is loaded into the output
//   register, so the next request can be taken while that result still
//   waits for the receiver.
//   A stalled result holds its payload; a finished request waits in its
//   result state until the output register is free.
//   Reset empties the queue (pointers, count and total weight to zero) and
//   drops any pending result; record storage is not cleared.
module ring_fifo_with_search_and_extrema #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 func,
  input  logic [63:0]                key,
  input  logic [31:0]                tag,
  input  logic [31:0]                weight,
  input  logic [15:0]                boxes,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic                       found,
  output logic                       full_res,
  output logic [$clog2(DEPTH+1)-1:0] occupancy,
  output logic [35:0]                total_weight,
  output logic [63:0]                rec_key,
  output logic [31:0]                rec_tag,
  output logic [31:0]                rec_weight,
  output logic [15:0]                rec_boxes
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = 32 + CW;
  localparam int XW = (SW > rfse_pkg::TWW) ? SW : rfse_pkg::TWW;
  localparam int RW = $bits(rfse_pkg::rec_t);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t          state;
  logic [AW-1:0]   head;
  logic [AW-1:0]   tail;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   left;
  logic [SW-1:0]   sum;
  logic            rd_valid;
  logic            first;
  logic [2:0]      func_q;
  logic [63:0]     key_q;
  rfse_pkg::rec_t  best;
  logic            found_q;
  logic            have_rec;
  logic [1:0]      status_q;

  logic            accept;
  logic            is_query;
  logic            is_full;
  logic            is_empty;
  logic            start_rd;
  logic            scan_rd;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [RW-1:0]   rd_data;
  rfse_pkg::rec_t  rd_rec;
  rfse_pkg::rec_t  wr_rec;
  logic [63:0]     cmp_a;
  logic [63:0]     cmp_b;
  logic            cmp_gt;
  logic            cmp_eq;
  logic            take;
  logic            out_free;
  logic [XW-1:0]   sum_x;
  logic [35:0]     sum_sat;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign is_query = (func == rfse_pkg::FN_POP) || (func == rfse_pkg::FN_SEARCH) ||
                    (func == rfse_pkg::FN_HEAVY) || (func == rfse_pkg::FN_FEWEST);
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  assign start_rd = accept && is_query && !is_empty;
  assign scan_rd  = (state == S_SCAN) && (left != '0);
  assign rd_en    = start_rd || scan_rd;
  assign rd_addr  = start_rd ? head : rd_ptr;
  assign wr_en    = accept && (func == rfse_pkg::FN_PUSH) && !is_full;

  assign wr_rec.key    = key;
  assign wr_rec.tag    = tag;
  assign wr_rec.weight = weight;
  assign wr_rec.boxes  = boxes;
  assign rd_rec        = rfse_pkg::rec_t'(rd_data);

  rfse_ram #(
    .WIDTH(RW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(tail),
    .wdata(RW'(wr_rec)),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Shared comparator: operands steered by the request in flight
  always_comb begin
    unique case (func_q)
      rfse_pkg::FN_HEAVY: begin
        cmp_a = 64'(rd_rec.weight);
        cmp_b = 64'(best.weight);
      end
      rfse_pkg::FN_FEWEST: begin
        cmp_a = 64'(best.boxes);
        cmp_b = 64'(rd_rec.boxes);
      end
      default: begin
        cmp_a = rd_rec.key;
        cmp_b = key_q;
      end
    endcase
  end

  assign cmp_gt = (cmp_a > cmp_b);
  assign cmp_eq = (cmp_a == cmp_b);
  // Strict compare keeps the entry nearest the head on ties
  assign take   = cmp_gt && ((func_q == rfse_pkg::FN_HEAVY) ||
                             (func_q == rfse_pkg::FN_FEWEST));

  assign sum_x   = XW'(sum);
  assign sum_sat = (sum_x > XW'(rfse_pkg::TW_MAX)) ? rfse_pkg::TW_MAX : 36'(sum_x);
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      sum       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      // Drop the taken result unless a new one is loaded in the same cycle
      if (out_valid && !out_stall && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            func_q   <= func;
            key_q    <= key;
            found_q  <= 1'b0;
            have_rec <= 1'b0;
            status_q <= rfse_pkg::ST_OK;
            first    <= 1'b1;
            state    <= S_RESULT;
            if (func == rfse_pkg::FN_PUSH) begin
              if (is_full) begin
                status_q <= rfse_pkg::ST_FULL;
              end else begin
                tail  <= ptr_inc(tail);
                count <= count + CW'(1);
                sum   <= sum + SW'(weight);
              end
            end else if (is_query) begin
              if (is_empty) begin
                status_q <= rfse_pkg::ST_EMPTY;
              end else begin
                have_rec <= (func != rfse_pkg::FN_SEARCH);
                rd_ptr   <= ptr_inc(head);
                state    <= S_SCAN;
                if (func == rfse_pkg::FN_POP) begin
                  head  <= ptr_inc(head);
                  count <= count - CW'(1);
                  left  <= '0;
                end else begin
                  left  <= count - CW'(1);
                end
              end
            end
          end
        end
        S_SCAN: begin
          if (scan_rd) begin
            rd_ptr <= ptr_inc(rd_ptr);
            left   <= left - CW'(1);
          end
          if (rd_valid) begin
            first <= 1'b0;
            if (first || take) begin
              best <= rd_rec;
            end
            if ((func_q == rfse_pkg::FN_SEARCH) && cmp_eq) begin
              found_q <= 1'b1;
            end
            if (func_q == rfse_pkg::FN_POP) begin
              sum <= sum - SW'(rd_rec.weight);
            end
            // Last read has returned: nothing left to issue
            if (left == '0) begin
              state <= S_RESULT;
            end
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= status_q;
            found        <= found_q;
            full_res     <= is_full;
            occupancy    <= count;
            total_weight <= sum_sat;
            rec_key      <= have_rec ? best.key : '0;
            rec_tag      <= have_rec ? best.tag : '0;
            rec_weight   <= have_rec ? best.weight : '0;
            rec_boxes    <= have_rec ? best.boxes : '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/rfse_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module rfse_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/rfse_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the ring FIFO with search and extrema.
// Uses rfse_pkg codes; bound to the top level at the end of this file.
module rfse_chk #(
  parameter int DEPTH = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 status,
  input logic                       found,
  input logic                       full_res,
  input logic [$clog2(DEPTH+1)-1:0] occupancy,
  input logic [35:0]                total_weight
);

  // One request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a request is in flight");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(occupancy) &&
    $stable(total_weight))
    else $error("stalled result changed");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (full_res == (occupancy == ($clog2(DEPTH+1))'(DEPTH))) &&
    (occupancy <= ($clog2(DEPTH+1))'(DEPTH)))
    else $error("full flag or occupancy out of line");

  a_reject_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == rfse_pkg::ST_FULL) |-> full_res)
    else $error("push rejected while not full");

  a_empty_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == rfse_pkg::ST_EMPTY) |-> (occupancy == '0) && !found &&
    (total_weight == '0))
    else $error("empty reject with entries or match");

endmodule

bind ring_fifo_with_search_and_extrema rfse_chk #(.DEPTH(DEPTH)) u_rfse_chk (.*);

// ----- sim/tb_ring_fifo_with_search_and_extrema.sv -----
`timescale 1ns / 1ps
// Testbench for ring_fifo_with_search_and_extrema: clocked driver and monitor,
// shadow queue that predicts each result. Depends on rfse_pkg and the RTL.
module tb_ring_fifo_with_search_and_extrema;

  localparam int QUEUE_DEPTH = 16;
  localparam logic [2:0] FN_UNUSED = 3'd7;  // unused code, request is ignored

  typedef struct {
    logic [2:0]      func;
    rfse_pkg::rec_t  rec;
    int              phase;
    bit              drain_first;
  } request_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            found;
    logic            full;
    logic [4:0]      occupancy;
    logic [35:0]     total_weight;
    rfse_pkg::rec_t  rec;
  } result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  func;
  logic [63:0] key;
  logic [31:0] tag;
  logic [31:0] weight;
  logic [15:0] boxes;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic        found;
  logic        full_res;
  logic [4:0]  occupancy;
  logic [35:0] total_weight;
  logic [63:0] rec_key;
  logic [31:0] rec_tag;
  logic [31:0] rec_weight;
  logic [15:0] rec_boxes;

  request_t request_q[$];
  result_t  expected_results[$];
  int       mismatches = 0;
  int       run_phase = 0;
  int       send_idle_pct[3] = '{7, 52, 0};
  int       recv_stall_pct[3] = '{52, 7, 0};

  // Shadow copy of the queue contents
  rfse_pkg::rec_t shadow_rec[QUEUE_DEPTH];
  logic [3:0]     shadow_head = '0;
  logic [3:0]     shadow_tail = '0;
  int             shadow_count = 0;

  // Key pool so searches hit queued entries often
  logic [63:0] key_pool[8];
  logic [31:0] weight_pool[4];

  ring_fifo_with_search_and_extrema #(.DEPTH(QUEUE_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .key(key), .tag(tag), .weight(weight), .boxes(boxes),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .found(found), .full_res(full_res), .occupancy(occupancy),
    .total_weight(total_weight), .rec_key(rec_key), .rec_tag(rec_tag),
    .rec_weight(rec_weight), .rec_boxes(rec_boxes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow queue and return the result it causes
  function automatic result_t queue_step(input logic [2:0] f, input rfse_pkg::rec_t r);
    result_t     res;
    logic [3:0]  i;
    logic [3:0]  heavy_sel;
    logic [3:0]  few_sel;
    logic [36:0] sum;
    int          j;
    res = '0;
    if (f == rfse_pkg::FN_PUSH) begin
      if (shadow_count == QUEUE_DEPTH) begin
        res.status = rfse_pkg::ST_FULL;
      end else begin
        shadow_rec[shadow_tail] = r;
        shadow_tail = shadow_tail + 4'd1;
        shadow_count++;
      end
    end else if (f <= rfse_pkg::FN_FEWEST) begin
      if (shadow_count == 0) begin
        res.status = rfse_pkg::ST_EMPTY;
      end else if (f == rfse_pkg::FN_POP) begin
        res.rec = shadow_rec[shadow_head];
        shadow_head = shadow_head + 4'd1;
        shadow_count--;
      end else begin
        i = shadow_head;
        heavy_sel = shadow_head;
        few_sel = shadow_head;
        for (j = 0; j < shadow_count; j++) begin
          if (f == rfse_pkg::FN_SEARCH && shadow_rec[i].key == r.key) res.found = 1'b1;
          // strict compare keeps the entry nearest the head on ties
          if (shadow_rec[i].weight > shadow_rec[heavy_sel].weight) heavy_sel = i;
          if (shadow_rec[i].boxes < shadow_rec[few_sel].boxes) few_sel = i;
          i = i + 4'd1;
        end
        if (f == rfse_pkg::FN_HEAVY) res.rec = shadow_rec[heavy_sel];
        if (f == rfse_pkg::FN_FEWEST) res.rec = shadow_rec[few_sel];
      end
    end
    sum = '0;
    i = shadow_head;
    for (j = 0; j < shadow_count; j++) begin
      sum = sum + shadow_rec[i].weight;
      i = i + 4'd1;
    end
    res.total_weight = (sum > rfse_pkg::TW_MAX) ? rfse_pkg::TW_MAX : sum[35:0];
    res.full = (shadow_count == QUEUE_DEPTH);
    res.occupancy = shadow_count[4:0];
    return res;
  endfunction

  // Driver: predict on accept, then present the next request
  always @(posedge clk) begin
    request_t       r;
    rfse_pkg::rec_t sent;
    logic           next_valid;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        sent = '{key: key, tag: tag, weight: weight, boxes: boxes};
        expected_results.push_back(queue_step(func, sent));
        next_valid = 1'b0;
      end
      if (!next_valid && request_q.size() > 0) begin
        r = request_q[0];
        if (!(r.drain_first && expected_results.size() != 0) &&
            $urandom_range(99) >= send_idle_pct[r.phase]) begin
          void'(request_q.pop_front());
          func <= r.func;
          key <= r.rec.key;
          tag <= r.rec.tag;
          weight <= r.rec.weight;
          boxes <= r.rec.boxes;
          run_phase <= r.phase;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Monitor: check each accepted result against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t exp_res;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{status: status, found: found, full: full_res, occupancy: occupancy,
                total_weight: total_weight,
                rec: '{key: rec_key, tag: rec_tag, weight: rec_weight, boxes: rec_boxes}};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_res = expected_results.pop_front();
          if (got.status !== exp_res.status || got.found !== exp_res.found ||
              got.full !== exp_res.full || got.occupancy !== exp_res.occupancy ||
              got.total_weight !== exp_res.total_weight ||
              got.rec.key !== exp_res.rec.key || got.rec.tag !== exp_res.rec.tag ||
              got.rec.weight !== exp_res.rec.weight ||
              got.rec.boxes !== exp_res.rec.boxes) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp st=%0d fd=%0d fu=%0d occ=%0d tw=%h rec=%h",
                       exp_res.status, exp_res.found, exp_res.full, exp_res.occupancy,
                       exp_res.total_weight, exp_res.rec);
              $display("          got st=%0d fd=%0d fu=%0d occ=%0d tw=%h rec=%h",
                       got.status, got.found, got.full, got.occupancy,
                       got.total_weight, got.rec);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct[run_phase]);
    end
  end

  task automatic add_request(input logic [2:0] f, input logic [63:0] k, input logic [31:0] t,
                             input logic [31:0] w, input logic [15:0] b, input int ph,
                             input bit drain);
    request_t r;
    r.func = f;
    r.rec = '{key: k, tag: t, weight: w, boxes: b};
    r.phase = ph;
    r.drain_first = drain;
    request_q.push_back(r);
  endtask

  initial begin
    int          n;
    int          ph;
    int          roll;
    int          gen_count;
    bit          filling;
    logic [2:0]  f;
    logic [63:0] k;
    logic [31:0] w;
    logic [15:0] b;
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    func = rfse_pkg::FN_PUSH;
    key = '0;
    tag = '0;
    weight = '0;
    boxes = '0;

    for (n = 0; n < 8; n++) key_pool[n] = {$urandom, $urandom};
    key_pool[0] = '1;
    key_pool[1] = '0;
    weight_pool = '{32'd0, 32'd250, 32'd250, 32'hFFFF_FFFF};

    // Requests on the empty queue are rejected; the unused code is ignored
    add_request(rfse_pkg::FN_POP, '1, '1, '1, '1, 0, 1'b0);
    add_request(rfse_pkg::FN_SEARCH, '0, '0, '0, '0, 0, 1'b0);
    add_request(rfse_pkg::FN_HEAVY, '1, '0, '1, '0, 0, 1'b0);
    add_request(rfse_pkg::FN_FEWEST, '0, '1, '0, '1, 0, 1'b0);
    add_request(FN_UNUSED, '1, '1, '1, '1, 0, 1'b0);
    // Fill to capacity with extremes and ties on weight and boxes, push once more, then query and pop
    add_request(rfse_pkg::FN_PUSH, '0, '0, '0, '0, 0, 1'b0);
    add_request(rfse_pkg::FN_PUSH, '1, '1, '1, '1, 0, 1'b0);
    for (n = 2; n < QUEUE_DEPTH; n++) begin
      w = (n == 6) ? 32'hFFFF_FFFF : $urandom;
      b = (n == 9) ? 16'd0 : 16'($urandom_range(1, 65535));
      add_request(rfse_pkg::FN_PUSH, key_pool[n % 8] ^ 64'(n), $urandom, w, b, 0, 1'b0);
    end
    add_request(rfse_pkg::FN_PUSH, '1, '1, '1, '1, 0, 1'b0);
    add_request(rfse_pkg::FN_HEAVY, '0, '0, '0, '0, 0, 1'b0);
    add_request(rfse_pkg::FN_FEWEST, '0, '0, '0, '0, 0, 1'b0);
    add_request(rfse_pkg::FN_SEARCH, key_pool[5] ^ 64'd5, '0, '0, '0, 0, 1'b0);
    add_request(rfse_pkg::FN_POP, '0, '0, '0, '0, 0, 1'b0);

    // Random part: alternate fill and drain passes so both ends get hit
    gen_count = QUEUE_DEPTH - 1;
    filling = 1'b0;
    for (n = 0; n < 950; n++) begin
      ph = n / 317;
      if (filling && gen_count == QUEUE_DEPTH && $urandom_range(2) == 0) filling = 1'b0;
      else if (!filling && gen_count == 0 && $urandom_range(2) == 0) filling = 1'b1;
      else if ($urandom_range(99) < 2) filling = !filling;
      roll = $urandom_range(99);
      if (roll < 2) f = 3'($urandom_range(5, 7));
      else if (roll < 14) f = rfse_pkg::FN_SEARCH;
      else if (roll < 22) f = rfse_pkg::FN_HEAVY;
      else if (roll < 30) f = rfse_pkg::FN_FEWEST;
      else if (filling) f = (roll < 35) ? rfse_pkg::FN_POP : rfse_pkg::FN_PUSH;
      else f = (roll < 40) ? rfse_pkg::FN_PUSH : rfse_pkg::FN_POP;
      k = ($urandom_range(99) < 60) ? key_pool[$urandom_range(7)] : {$urandom, $urandom};
      w = ($urandom_range(99) < 30) ? weight_pool[$urandom_range(3)] : $urandom;
      b = ($urandom_range(99) < 30) ? 16'($urandom_range(3)) : 16'($urandom);
      add_request(f, k, $urandom, w, b, ph, (n % 317 == 0) || ($urandom_range(99) == 0));
      if (f == rfse_pkg::FN_PUSH && gen_count < QUEUE_DEPTH) gen_count++;
      if (f == rfse_pkg::FN_POP && gen_count > 0) gen_count--;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
